/* src/fegu_pkg.sv */
// Package for the fast exp / gauss unit: operation codes, float constants,
// the operand class struct and small helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fegu_pkg;

  typedef enum logic [1:0] {
    CMD_EXP    = 2'd0,
    CMD_GAUSS  = 2'd1,
    CMD_DGAUSS = 2'd2
  } fegu_cmd_t;

  localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
  localparam logic [31:0] SCALE_BITS = 32'h4B38_AA3B;  // 12102203.0
  localparam logic [31:0] EXP_BIAS   = 32'h3F80_0000;  // 127 << 23
  localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;

  localparam logic [10:0] CORR_K1 = 11'd1277;
  localparam logic [14:0] CORR_K2 = 15'd14825;
  localparam logic signed [17:0] CORR_K3 = 18'sd79749;
  localparam logic signed [24:0] CORR_K4 = 25'sd626;

  typedef struct packed {
    logic sign;
    logic nan;
    logic inf;
    logic zero;
  } fegu_cls_t;

  // Leading zero count of a 24-bit mantissa.
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] lz;
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) lz = 5'(23 - i);
    end
    return lz;
  endfunction

  // Exact -2*x on a single-precision pattern (overflow goes to infinity).
  function automatic logic [31:0] neg2x(input logic [31:0] x);
    logic [31:0] s;
    if (x[30:23] == 8'hFF) begin
      s = {~x[31], x[30:0]};
    end else if (x[30:23] == 8'h00) begin
      s = {~x[31], x[29:0], 1'b0};
    end else if (x[30:23] == 8'hFE) begin
      s = {~x[31], 8'hFF, 23'd0};
    end else begin
      s = {~x[31], x[30:23] + 8'd1, x[22:0]};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* src/fegu_fmul.sv */
// Three-stage single-precision multiplier, round to nearest even, with
// subnormals. Uses fegu_pkg for the class struct and helpers.
`timescale 1ns / 1ps
`default_nettype none

module fegu_fmul import fegu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  // Unpack stage.
  fegu_cls_t               cls_u, cls_u_next;
  logic [23:0]             ma_u, mb_u, ma_next, mb_next;
  logic signed [10:0]      e_u, e_u_next;

  // Product stage.
  fegu_cls_t               cls_p;
  logic [47:0]             prod;
  logic signed [10:0]      e_p;

  always_comb begin
    logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [23:0] mant_a, mant_b;
    logic [4:0]  lza, lzb;
    logic signed [9:0] xa, xb;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    b_zero = (b[30:0] == 31'd0);
    mant_a = {a[30:23] != 8'd0, a[22:0]};
    mant_b = {b[30:23] != 8'd0, b[22:0]};
    lza = lzc24(mant_a);
    lzb = lzc24(mant_b);
    ma_next = mant_a << lza;
    mb_next = mant_b << lzb;
    xa = ((a[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, a[30:23]})) - $signed({5'd0, lza});
    xb = ((b[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, b[30:23]})) - $signed({5'd0, lzb});
    e_u_next = 11'(xa) + 11'(xb) - 11'sd127;
    cls_u_next.sign = a[31] ^ b[31];
    cls_u_next.nan  = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
    cls_u_next.inf  = (a_inf | b_inf) & ~cls_u_next.nan;
    cls_u_next.zero = (a_zero | b_zero) & ~cls_u_next.nan & ~cls_u_next.inf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_u <= cls_u_next;
      ma_u  <= ma_next;
      mb_u  <= mb_next;
      e_u   <= e_u_next;
      cls_p <= cls_u;
      prod  <= ma_u * mb_u;
      e_p   <= e_u;
    end
  end

  // Normalize, shift into the subnormal range if needed, round and pack.
  logic [31:0] y_next;

  always_comb begin
    logic [47:0]        nm, shifted, mask;
    logic signed [10:0] er, dif;
    logic [5:0]         sh;
    logic               lost, gb, st, rnd, ovf;
    logic [23:0]        kept;
    logic [7:0]         ef;
    logic [30:0]        mag;
    if (prod[47]) begin
      nm = prod;
      er = e_p + 11'sd1;
    end else begin
      nm = prod << 1;
      er = e_p;
    end
    ovf = (er >= 11'sd255);
    dif = 11'sd1 - er;
    if (er >= 11'sd1) begin
      sh = 6'd0;
    end else if (dif > 11'sd48) begin
      sh = 6'd48;
    end else begin
      sh = dif[5:0];
    end
    shifted = nm >> sh;
    mask    = ~({48{1'b1}} << sh);
    lost    = |(nm & mask);
    kept    = shifted[47:24];
    gb      = shifted[23];
    st      = (|shifted[22:0]) | lost;
    rnd     = gb & (st | kept[0]);
    ef      = (er < 11'sd1) ? 8'd0 : er[7:0];
    mag     = {ef, kept[22:0]} + {30'd0, rnd};
    if (cls_p.nan) begin
      y_next = QNAN_BITS;
    end else if (cls_p.inf || (ovf && !cls_p.zero)) begin
      y_next = {cls_p.sign, 8'hFF, 23'd0};
    end else if (cls_p.zero) begin
      y_next = {cls_p.sign, 31'd0};
    end else begin
      y_next = {cls_p.sign, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= y_next;
    end
  end

endmodule

`default_nettype wire

/* src/fast_exp_gauss_unit.sv */
// Top level of the fast exp / gauss unit: three float multipliers, the
// integer exp stages with the cubic correction, and the result select.
// Depends on fegu_pkg and fegu_fmul.
//
//   channel | words        | handshake
//   --------+--------------+----------------------
//   input   | cmd, x_bits  | in_valid / in_ready
//   output  | y_bits       | out_valid / out_ready
//
// One word enters per cycle when the output is taken.
// The pipeline is three 3-stage multipliers, five integer exp stages and
// an output register; the chained multiplies set the depth.
// All stages advance together; when the output word waits, the whole
// pipeline holds and in_ready drops. Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module fast_exp_gauss_unit import fegu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] x_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      y_bits
);

  localparam int Depth = 15;

  logic              en;
  logic [Depth-1:0]  vld;
  logic [1:0]        cmd_d [0:Depth-1];
  logic [31:0]       x_d   [0:10];

  assign en        = !vld[Depth-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_d[0] <= cmd;
      x_d[0]   <= x_bits;
      for (int k = 1; k < Depth; k++) cmd_d[k] <= cmd_d[k-1];
      for (int k = 1; k < 11; k++) x_d[k] <= x_d[k-1];
    end
  end

  // First multiply: (-x)*x for gauss and its derivative, 1*x for exp.
  logic [31:0] m1_a, sq, p;

  always_comb begin
    case (cmd)
      CMD_GAUSS, CMD_DGAUSS: m1_a = {~x_bits[31], x_bits[30:0]};
      default:               m1_a = ONE_BITS;
    endcase
  end

  fegu_fmul u_mul_sq (.clk(clk), .en(en), .a(m1_a), .b(x_bits), .y(sq));
  fegu_fmul u_mul_sc (.clk(clk), .en(en), .a(SCALE_BITS), .b(sq), .y(p));

  // Truncate with saturation, then add the exponent bias.
  logic [31:0] t, w6, w7, w8, w9;
  logic [15:0] m6, m7, m8;

  always_comb begin
    logic [30:0] mag;
    logic [4:0]  sh;
    mag = 31'd0;
    sh  = 5'd0;
    if (p[30:23] == 8'hFF && p[22:0] != 23'd0) begin
      t = 32'd0;
    end else if (p[30:23] >= 8'd158) begin
      t = p[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (p[30:23] < 8'd127) begin
      t = 32'd0;
    end else begin
      sh  = 5'(8'd157 - p[30:23]);
      mag = {1'b1, p[22:0], 7'd0} >> sh;
      t   = p[31] ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
    end
  end

  // Cubic correction over mantissa bits 22..7, one multiply per stage.
  logic [26:0]        pa7;
  logic [30:0]        pb8;
  logic signed [34:0] pc9;
  logic [14:0]        a_coef;
  logic signed [17:0] b_coef;
  logic signed [24:0] corr;
  logic [31:0]        w_next, g10;

  assign w_next = t + EXP_BIAS;
  assign a_coef = {2'b00, pa7[26:14]} + CORR_K2;
  assign b_coef = $signed({1'b0, pb8[30:14]}) - CORR_K3;
  assign corr   = 25'(pc9 >>> 11) - CORR_K4;

  always_ff @(posedge clk) begin
    if (en) begin
      w6  <= w_next;
      m6  <= w_next[22:7];
      pa7 <= 27'(CORR_K1 * m6);
      w7  <= w6;
      m7  <= m6;
      pb8 <= 31'(a_coef * m7);
      w8  <= w7;
      m8  <= m7;
      pc9 <= 35'(b_coef * $signed({1'b0, m8}));
      w9  <= w8;
      g10 <= w9 + 32'(corr);
    end
  end

  // Derivative: (-2*x) * gauss(x).
  logic [31:0] s10, r13;
  logic [31:0] g_d [11:13];

  assign s10 = neg2x(x_d[10]);

  fegu_fmul u_mul_dv (.clk(clk), .en(en), .a(s10), .b(g10), .y(r13));

  always_ff @(posedge clk) begin
    if (en) begin
      g_d[11] <= g10;
      g_d[12] <= g_d[11];
      g_d[13] <= g_d[12];
    end
  end

  logic [31:0] y_next;

  always_comb begin
    case (cmd_d[13])
      CMD_EXP, CMD_GAUSS: y_next = g_d[13];
      CMD_DGAUSS:         y_next = r13;
      default:            y_next = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_bits <= y_next;
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word did not enter the first stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(vld))
    else $error("pipeline moved while the output was stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while the output stage is empty");

  a_deriv_nan_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && cmd_d[Depth-1] == CMD_DGAUSS && y_bits[30:23] == 8'hFF
      && y_bits[22:0] != 23'd0 |-> y_bits == QNAN_BITS)
    else $error("derivative NaN is not the canonical quiet NaN");

endmodule

`default_nettype wire
